[hw/rtl/tkfmh_pkg.sv]
// Package: payload structs, heap entry type, status codes and sequencer states.
package tkfmh_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [30:0] estimate;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [6:0]  occupancy;
    logic [30:0] min_estimate;
    logic [31:0] evicted_saddr;
    logic [31:0] evicted_daddr;
    logic [15:0] evicted_sport;
    logic [15:0] evicted_dport;
    logic [7:0]  evicted_proto;
    logic [30:0] evicted_estimate;
  } out_t;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [30:0] estimate;
  } entry_t;

  typedef enum logic [2:0] {
    StMoved     = 3'd0,
    StUnchanged = 3'd1,
    StInserted  = 3'd2,
    StReplaced  = 3'd3,
    StRejected  = 3'd4,
    StCleared   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SSrchRd,
    SSrchCk,
    SMiss,
    SRootRd,
    SRootCk,
    SUpRd,
    SUpCk,
    SDownRd,
    SDownCk1,
    SDownCk2,
    SDownMv,
    SWriteFinal,
    SDone
  } state_e;

  localparam logic       ReqClear    = 1'b1;
  localparam logic [6:0] ActiveKRst  = 7'd64;

endpackage

[hw/rtl/topk_flow_min_heap_unit.sv]
// Top level: top-K flow tracker on a binary min-heap held in one entry memory.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (tkfmh_pkg::in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (tkfmh_pkg::out_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (active_k)
//
// One transaction at a time. The single memory read port sets the pace: the
// key search reads and checks each held flow in turn, each sift-up level
// reads the parent and each sift-down level reads up to two children. A
// clear touches no memory. Reset empties the heap at once (no clearing pass:
// slots beyond the fill count are never read). A stalled result holds in
// the status registers and the block stays not ready until it is taken.
module topk_flow_min_heap_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tkfmh_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tkfmh_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_wdata_i
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CW > 7) ? CW : 7;

  tkfmh_pkg::state_e state_q, state_d;

  // Heap storage: slot n lives at address n-1.
  tkfmh_pkg::entry_t mem_q [MAX_ENTRIES];
  tkfmh_pkg::entry_t rd_q;
  logic [IW-1:0]     rd_addr;
  logic              we;
  logic [IW-1:0]     wr_addr;
  tkfmh_pkg::entry_t wr_data;

  logic [6:0]        active_k_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [30:0]       root_est_q, root_est_d;
  tkfmh_pkg::in_t    req_q, req_d;
  tkfmh_pkg::entry_t cur_q, cur_d;
  tkfmh_pkg::entry_t ev_q, ev_d;
  tkfmh_pkg::entry_t sel_ent_q, sel_ent_d;
  logic              sel_q, sel_d;
  logic [CW-1:0]     sel_pos_q, sel_pos_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              moved_q, moved_d;
  logic [2:0]        status_q, status_d;
  logic [6:0]        slot_q, slot_d;

  tkfmh_pkg::entry_t new_ent;
  logic [CmpW-1:0]   k_eff, cnt_ext;
  logic              key_hit, last_idx, full;
  logic [CW:0]       c1, c2;
  logic [CW-1:0]     parent, idx_slot;
  logic [30:0]       small_est;

  assign new_ent = '{saddr: req_q.saddr, daddr: req_q.daddr,
                     sport: req_q.sport, dport: req_q.dport,
                     proto: req_q.proto, estimate: req_q.estimate};

  // Clamp active_k into 1..MAX_ENTRIES.
  always_comb begin
    if (active_k_q == 7'd0) begin
      k_eff = CmpW'(1);
    end else if (CmpW'(active_k_q) > CmpW'(MAX_ENTRIES)) begin
      k_eff = CmpW'(MAX_ENTRIES);
    end else begin
      k_eff = CmpW'(active_k_q);
    end
  end

  assign cnt_ext   = CmpW'(cnt_q);
  assign full      = (cnt_ext >= k_eff);
  assign key_hit   = (rd_q.saddr == req_q.saddr) && (rd_q.daddr == req_q.daddr)
                  && (rd_q.sport == req_q.sport) && (rd_q.dport == req_q.dport)
                  && (rd_q.proto == req_q.proto);
  assign idx_slot  = CW'(idx_q) + CW'(1);
  assign last_idx  = (idx_slot >= cnt_q);
  assign c1        = {pos_q, 1'b0};
  assign c2        = c1 + (CW+1)'(1);
  assign parent    = pos_q >> 1;
  assign small_est = sel_q ? sel_ent_q.estimate : cur_q.estimate;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkfmh_pkg::SIdle: begin
        if (in_valid_i) begin
          if (in_data_i.req_type == tkfmh_pkg::ReqClear) begin
            state_d = tkfmh_pkg::SDone;
          end else if (cnt_q == '0) begin
            state_d = tkfmh_pkg::SMiss;
          end else begin
            state_d = tkfmh_pkg::SSrchRd;
          end
        end
      end
      tkfmh_pkg::SSrchRd: state_d = tkfmh_pkg::SSrchCk;
      tkfmh_pkg::SSrchCk: begin
        if (key_hit) begin
          state_d = (rd_q.estimate == req_q.estimate) ? tkfmh_pkg::SDone : tkfmh_pkg::SUpRd;
        end else if (last_idx) begin
          state_d = tkfmh_pkg::SMiss;
        end else begin
          state_d = tkfmh_pkg::SSrchRd;
        end
      end
      tkfmh_pkg::SMiss:   state_d = full ? tkfmh_pkg::SRootRd : tkfmh_pkg::SUpRd;
      tkfmh_pkg::SRootRd: state_d = tkfmh_pkg::SRootCk;
      tkfmh_pkg::SRootCk: begin
        state_d = (rd_q.estimate < req_q.estimate) ? tkfmh_pkg::SDownRd : tkfmh_pkg::SDone;
      end
      tkfmh_pkg::SUpRd: begin
        if (pos_q > CW'(1)) begin
          state_d = tkfmh_pkg::SUpCk;
        end else begin
          state_d = moved_q ? tkfmh_pkg::SWriteFinal : tkfmh_pkg::SDownRd;
        end
      end
      tkfmh_pkg::SUpCk: begin
        if (rd_q.estimate > cur_q.estimate) begin
          state_d = tkfmh_pkg::SUpRd;
        end else begin
          state_d = moved_q ? tkfmh_pkg::SWriteFinal : tkfmh_pkg::SDownRd;
        end
      end
      tkfmh_pkg::SDownRd: begin
        state_d = (c1 <= (CW+1)'(cnt_q)) ? tkfmh_pkg::SDownCk1 : tkfmh_pkg::SWriteFinal;
      end
      tkfmh_pkg::SDownCk1: begin
        state_d = (c2 <= (CW+1)'(cnt_q)) ? tkfmh_pkg::SDownCk2 : tkfmh_pkg::SDownMv;
      end
      tkfmh_pkg::SDownCk2: state_d = tkfmh_pkg::SDownMv;
      tkfmh_pkg::SDownMv: begin
        state_d = sel_q ? tkfmh_pkg::SDownRd : tkfmh_pkg::SWriteFinal;
      end
      tkfmh_pkg::SWriteFinal: state_d = tkfmh_pkg::SDone;
      tkfmh_pkg::SDone: begin
        if (out_ready_i) begin
          state_d = tkfmh_pkg::SIdle;
        end
      end
      default: state_d = tkfmh_pkg::SIdle;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    req_d      = req_q;
    cur_d      = cur_q;
    ev_d       = ev_q;
    sel_d      = sel_q;
    sel_ent_d  = sel_ent_q;
    sel_pos_d  = sel_pos_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    moved_d    = moved_q;
    status_d   = status_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = IW'(pos_q - CW'(1));
    wr_data    = cur_q;
    unique case (state_q)
      tkfmh_pkg::SIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          ev_d    = '0;
          idx_d   = '0;
          moved_d = 1'b0;
          slot_d  = '0;
          if (in_data_i.req_type == tkfmh_pkg::ReqClear) begin
            cnt_d    = '0;
            status_d = tkfmh_pkg::StCleared;
          end
        end
      end
      tkfmh_pkg::SSrchRd: rd_addr = idx_q;
      tkfmh_pkg::SSrchCk: begin
        if (key_hit) begin
          if (rd_q.estimate == req_q.estimate) begin
            status_d = tkfmh_pkg::StUnchanged;
            slot_d   = 7'(idx_slot);
          end else begin
            status_d = tkfmh_pkg::StMoved;
            cur_d    = new_ent;
            pos_d    = idx_slot;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      tkfmh_pkg::SMiss: begin
        if (!full) begin
          cnt_d    = cnt_q + CW'(1);
          pos_d    = cnt_q + CW'(1);
          cur_d    = new_ent;
          status_d = tkfmh_pkg::StInserted;
        end
      end
      tkfmh_pkg::SRootRd: rd_addr = '0;
      tkfmh_pkg::SRootCk: begin
        if (rd_q.estimate < req_q.estimate) begin
          ev_d     = rd_q;
          cur_d    = new_ent;
          pos_d    = CW'(1);
          status_d = tkfmh_pkg::StReplaced;
        end else begin
          status_d = tkfmh_pkg::StRejected;
        end
      end
      tkfmh_pkg::SUpRd: rd_addr = IW'(parent - CW'(1));
      tkfmh_pkg::SUpCk: begin
        // Move the larger parent down into the hole.
        if (rd_q.estimate > cur_q.estimate) begin
          we      = 1'b1;
          wr_data = rd_q;
          pos_d   = parent;
          moved_d = 1'b1;
        end
      end
      tkfmh_pkg::SDownRd: begin
        rd_addr = IW'(c1 - (CW+1)'(1));
        sel_d   = 1'b0;
      end
      tkfmh_pkg::SDownCk1: begin
        rd_addr = IW'(c2 - (CW+1)'(1));
        if (cur_q.estimate > rd_q.estimate) begin
          sel_d     = 1'b1;
          sel_ent_d = rd_q;
          sel_pos_d = CW'(c1);
        end
      end
      tkfmh_pkg::SDownCk2: begin
        if (small_est > rd_q.estimate) begin
          sel_d     = 1'b1;
          sel_ent_d = rd_q;
          sel_pos_d = CW'(c2);
        end
      end
      tkfmh_pkg::SDownMv: begin
        // Pull the smaller child up into the hole.
        if (sel_q) begin
          we      = 1'b1;
          wr_data = sel_ent_q;
          pos_d   = sel_pos_q;
        end
      end
      tkfmh_pkg::SWriteFinal: begin
        we     = 1'b1;
        slot_d = 7'(pos_q);
      end
      tkfmh_pkg::SDone: ;
      default: ;
    endcase
  end

  always_comb begin
    root_est_d = root_est_q;
    if (we && (wr_addr == '0)) begin
      root_est_d = wr_data.estimate;
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o  = (state_q == tkfmh_pkg::SIdle);
    out_valid_o = (state_q == tkfmh_pkg::SDone);
    out_data_o  = '{status: status_q, slot: slot_q, occupancy: 7'(cnt_q),
                    min_estimate: (cnt_q != '0) ? root_est_q : 31'd0,
                    evicted_saddr: ev_q.saddr, evicted_daddr: ev_q.daddr,
                    evicted_sport: ev_q.sport, evicted_dport: ev_q.dport,
                    evicted_proto: ev_q.proto, evicted_estimate: ev_q.estimate};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tkfmh_pkg::SIdle;
      active_k_q <= tkfmh_pkg::ActiveKRst;
      cnt_q      <= '0;
      root_est_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      root_est_q <= root_est_d;
      if (cfg_we_i) begin
        active_k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cur_q     <= cur_d;
    ev_q      <= ev_d;
    sel_q     <= sel_d;
    sel_ent_q <= sel_ent_d;
    sel_pos_q <= sel_pos_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    moved_q   <= moved_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
  end

endmodule
